// File: sv/ds_twr_time_of_flight_defines.svh
// Assertion macros shared by the ranging checker.
`ifndef DS_TWR_TIME_OF_FLIGHT_DEFINES_SVH
`define DS_TWR_TIME_OF_FLIGHT_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define DSTWR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ranging checker: property violated");

// Check a property on every rising clock edge, reset included.
`define DSTWR_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("ranging checker: property violated");

`endif

// File: sv/dstwr_pkg.sv
// Widths, constants and the divider word type of the ranging block.
package dstwr_pkg;

   localparam int STAMP_BITS    = 40;
   localparam int DEN_W         = STAMP_BITS + 2;
   localparam int MAG_W         = 2 * STAMP_BITS;
   localparam int LO_W          = STAMP_BITS / 2;
   localparam int HI_W          = STAMP_BITS - LO_W;
   localparam int QUO_W         = 32;
   localparam int BITS_PER_STEP = 2;
   localparam int DIV_STAGES    = QUO_W / BITS_PER_STEP;
   localparam int SH_W          = DEN_W + QUO_W;
   localparam int CMP_W         = (MAG_W > SH_W) ? MAG_W : SH_W;

   localparam logic [QUO_W-1:0] POS_LIMIT = {1'b0, {(QUO_W-1){1'b1}}};
   localparam logic [QUO_W-1:0] NEG_LIMIT = {1'b1, {(QUO_W-1){1'b0}}};

   // One word in flight through the divider stages.
   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [QUO_W-1:0] quo;
      logic [QUO_W-1:0] low;
      logic [DEN_W-1:0] den;
      logic             neg;
      logic             big;
      logic             zden;
   } div_state_type;

endpackage

// File: sv/dstwr_div_step.sv
// One registered stage of the restoring divider, two quotient bits (BITS_PER_STEP) per stage.
module dstwr_div_step
   import dstwr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          stage_valid,
   input  div_state_type stage_word,
   output logic          valid_ff,
   output div_state_type step_ff
);

   div_state_type step_in;

   // Shift in each next dividend bit and subtract where the remainder allows.
   always_comb begin
      div_state_type s;
      logic [DEN_W:0] trial;
      s = stage_word;
      trial = '0;
      for (int i = 0; i < BITS_PER_STEP; i++) begin
         trial = {s.rem, s.low[QUO_W-1]};
         s.low = s.low << 1;
         if (trial >= {1'b0, s.den}) begin
            trial = trial - {1'b0, s.den};
            s.quo = {s.quo[QUO_W-2:0], 1'b1};
         end else begin
            s.quo = {s.quo[QUO_W-2:0], 1'b0};
         end
         s.rem = trial[DEN_W-1:0];
      end
      step_in = s;
   end

   // Advance the word with its valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         step_ff <= step_in;
      end
   end

endmodule

// File: sv/ds_twr_time_of_flight.sv
// Top level: double-sided two-way ranging time of flight pipeline.
//
// Input channel req_*: six timestamps of one poll/response/final exchange,
// one word per accepted handshake (req_valid high, req_stall low).
// Result channel rsp_*: flight time, signed and truncated toward zero, with
// a zero-denominator flag and a saturation flag.
// The word passes 22 register stages on its way to rsp_*: one stage forms the
// round and reply times (loaded at the accepting edge), two stages run the
// split multipliers, one takes the signed difference, one sets up the
// divider, sixteen divider stages retire two quotient bits each, and one
// stage clamps into the output.
// Throughput is one word per cycle when no stall holds it, set by the fully staged divider.
// Reset clears all valid bits; the pipeline then holds no words.
// While rsp_valid is high and rsp_stall is high the whole pipeline holds,
// req_stall is raised, and the pending result stays unchanged on rsp_*.
module ds_twr_time_of_flight
   import dstwr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [STAMP_BITS-1:0] req_tag_poll_tx_time,
   input  logic [STAMP_BITS-1:0] req_anchor_resp_rx_time,
   input  logic [STAMP_BITS-1:0] req_tag_final_tx_time,
   input  logic [STAMP_BITS-1:0] req_anchor_resp_tx_time,
   input  logic [STAMP_BITS-1:0] req_tag_final_rx_time,
   input  logic [STAMP_BITS-1:0] req_tag_poll_rx_time,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [31:0]    rsp_flight_time,
   output logic                  rsp_zero_denominator,
   output logic                  rsp_saturated
);

   logic advance;

   logic                  s1_valid_ff;
   logic [STAMP_BITS-1:0] ra_ff, rb_ff, da_ff, db_ff;

   logic                  s2_valid_ff;
   logic [2*LO_W-1:0]     ll1_ff, ll2_ff;
   logic [LO_W+HI_W-1:0]  lh1_ff, hl1_ff, lh2_ff, hl2_ff;
   logic [2*HI_W-1:0]     hh1_ff, hh2_ff;
   logic [DEN_W-1:0]      den2_ff;

   logic                  s3_valid_ff;
   logic [MAG_W-1:0]      p1_ff, p2_ff;
   logic [DEN_W-1:0]      den3_ff;

   logic                  s4_valid_ff;
   logic [MAG_W-1:0]      mag_ff;
   logic                  neg4_ff;
   logic [DEN_W-1:0]      den4_ff;

   logic                  div_valid [0:DIV_STAGES];
   div_state_type         div_word  [0:DIV_STAGES];
   div_state_type         s5_in;
   logic [MAG_W-1:0]      mag_hi;

   logic                  out_valid_ff;
   logic [QUO_W-1:0]      flight_ff, flight_in;
   logic                  zden_ff, sat_ff, sat_in;

   // Hold everything while a finished word waits on a stalled receiver.
   assign advance   = !(out_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // Stage 1: round and reply times, wrapped to the stamp width.
   always_ff @(posedge clock) begin
      if (advance) begin
         ra_ff <= req_anchor_resp_rx_time - req_tag_poll_tx_time;
         db_ff <= req_anchor_resp_tx_time - req_tag_poll_rx_time;
         rb_ff <= req_tag_final_rx_time - req_anchor_resp_tx_time;
         da_ff <= req_tag_final_tx_time - req_anchor_resp_rx_time;
      end
   end

   // Stage 2: partial products on half-width slices, denominator sum.
   always_ff @(posedge clock) begin
      if (advance) begin
         ll1_ff  <= ra_ff[LO_W-1:0] * rb_ff[LO_W-1:0];
         lh1_ff  <= (LO_W+HI_W)'(ra_ff[LO_W-1:0]) * (LO_W+HI_W)'(rb_ff[STAMP_BITS-1:LO_W]);
         hl1_ff  <= (LO_W+HI_W)'(ra_ff[STAMP_BITS-1:LO_W]) * (LO_W+HI_W)'(rb_ff[LO_W-1:0]);
         hh1_ff  <= rb_ff[STAMP_BITS-1:LO_W] * ra_ff[STAMP_BITS-1:LO_W];
         ll2_ff  <= da_ff[LO_W-1:0] * db_ff[LO_W-1:0];
         lh2_ff  <= (LO_W+HI_W)'(da_ff[LO_W-1:0]) * (LO_W+HI_W)'(db_ff[STAMP_BITS-1:LO_W]);
         hl2_ff  <= (LO_W+HI_W)'(da_ff[STAMP_BITS-1:LO_W]) * (LO_W+HI_W)'(db_ff[LO_W-1:0]);
         hh2_ff  <= da_ff[STAMP_BITS-1:LO_W] * db_ff[STAMP_BITS-1:LO_W];
         den2_ff <= DEN_W'(ra_ff) + DEN_W'(rb_ff) + DEN_W'(da_ff) + DEN_W'(db_ff);
      end
   end

   // Stage 3: assemble the two full products.
   always_ff @(posedge clock) begin
      if (advance) begin
         p1_ff   <= MAG_W'(ll1_ff) + (MAG_W'(lh1_ff) << LO_W) + (MAG_W'(hl1_ff) << LO_W)
                  + (MAG_W'(hh1_ff) << (2*LO_W));
         p2_ff   <= MAG_W'(ll2_ff) + (MAG_W'(lh2_ff) << LO_W) + (MAG_W'(hl2_ff) << LO_W)
                  + (MAG_W'(hh2_ff) << (2*LO_W));
         den3_ff <= den2_ff;
      end
   end

   // Stage 4: sign and magnitude of the numerator.
   always_ff @(posedge clock) begin
      if (advance) begin
         neg4_ff <= p1_ff < p2_ff;
         mag_ff  <= (p1_ff < p2_ff) ? (p2_ff - p1_ff) : (p1_ff - p2_ff);
         den4_ff <= den3_ff;
      end
   end

   // Stage 5: flag an oversized quotient and seed the divider remainder.
   assign mag_hi = mag_ff >> QUO_W;

   always_comb begin
      s5_in.rem  = mag_hi[DEN_W-1:0];
      s5_in.quo  = '0;
      s5_in.low  = mag_ff[QUO_W-1:0];
      s5_in.den  = den4_ff;
      s5_in.neg  = neg4_ff;
      s5_in.big  = CMP_W'(mag_ff) >= (CMP_W'(den4_ff) << QUO_W);
      s5_in.zden = (den4_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         div_word[0] <= s5_in;
      end
   end

   // Advance the valid bits of the front stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         div_valid[0] <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         div_valid[0] <= s4_valid_ff;
      end
   end

   // Divider stages.
   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      dstwr_div_step u_step (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .stage_valid (div_valid[g]),
         .stage_word  (div_word[g]),
         .valid_ff    (div_valid[g+1]),
         .step_ff     (div_word[g+1])
      );
   end

   // Clamp to the signed result range and apply the sign; a zero denominator gives zero.
   always_comb begin
      div_state_type w;
      w = div_word[DIV_STAGES];
      if (w.zden) begin
         sat_in    = 1'b0;
         flight_in = '0;
      end else if (!w.neg) begin
         sat_in    = w.big || w.quo[QUO_W-1];
         flight_in = sat_in ? POS_LIMIT : w.quo;
      end else begin
         sat_in    = w.big || (w.quo > NEG_LIMIT);
         flight_in = sat_in ? NEG_LIMIT : (QUO_W'(0) - w.quo);
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= div_valid[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         flight_ff <= flight_in;
         zden_ff   <= div_word[DIV_STAGES].zden;
         sat_ff    <= sat_in;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_flight_time      = flight_ff;
   assign rsp_zero_denominator = zden_ff;
   assign rsp_saturated        = sat_ff;

endmodule

// File: sv/dstwr_checker.sv
// Port-level checker for the ranging block and its bind.
`include "ds_twr_time_of_flight_defines.svh"

module dstwr_checker
   import dstwr_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic signed [31:0]    rsp_flight_time,
   input logic                  rsp_zero_denominator,
   input logic                  rsp_saturated
);

   logic        zden_clean;
   logic        at_limit;
   logic [33:0] rsp_word;

   assign zden_clean = (rsp_flight_time == 0) && !rsp_saturated;
   assign at_limit   = (rsp_flight_time == $signed(POS_LIMIT))
                    || (rsp_flight_time == $signed(NEG_LIMIT));
   assign rsp_word   = {rsp_flight_time, rsp_zero_denominator, rsp_saturated};

   // A zero denominator gives a zero, unclamped result.
   `DSTWR_ASSERT(a_zden_result, clock, reset, rsp_valid && rsp_zero_denominator |-> zden_clean)

   // A clamped result sits on one of the two range limits.
   `DSTWR_ASSERT(a_sat_limit, clock, reset, rsp_valid && rsp_saturated |-> at_limit)

   // Input stalls only behind a stalled pending result.
   `DSTWR_ASSERT_ALWAYS(a_stall_cause, clock, req_stall |-> rsp_valid && rsp_stall)

   // A stalled result word holds.
   `DSTWR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))

endmodule

bind ds_twr_time_of_flight dstwr_checker u_dstwr_checker (
   .clock                (clock),
   .reset                (reset),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_flight_time      (rsp_flight_time),
   .rsp_zero_denominator (rsp_zero_denominator),
   .rsp_saturated        (rsp_saturated)
);

// File: tb/sv/tb_ds_twr_time_of_flight.sv
// Self-checking testbench for the double-sided two-way ranging time of flight block.
module tb_ds_twr_time_of_flight
   import dstwr_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [STAMP_BITS-1:0] STAMP_MAX = {STAMP_BITS{1'b1}};
   localparam int RANDOM_WORDS = 830;
   localparam int STALL_LIMIT  = 5000;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [STAMP_BITS-1:0] poll_tx;
      logic [STAMP_BITS-1:0] resp_rx;
      logic [STAMP_BITS-1:0] final_tx;
      logic [STAMP_BITS-1:0] resp_tx;
      logic [STAMP_BITS-1:0] final_rx;
      logic [STAMP_BITS-1:0] poll_rx;
   } exchange_type;

   typedef struct packed {
      logic signed [31:0] tof;
      logic               zden;
      logic               sat;
   } tof_result_type;

   typedef struct {
      exchange_type   stamps;
      bit             known;
      tof_result_type answer;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [STAMP_BITS-1:0] req_tag_poll_tx_time = '0;
   logic [STAMP_BITS-1:0] req_anchor_resp_rx_time = '0;
   logic [STAMP_BITS-1:0] req_tag_final_tx_time = '0;
   logic [STAMP_BITS-1:0] req_anchor_resp_tx_time = '0;
   logic [STAMP_BITS-1:0] req_tag_final_rx_time = '0;
   logic [STAMP_BITS-1:0] req_tag_poll_rx_time = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic signed [31:0]    rsp_flight_time;
   logic                  rsp_zero_denominator;
   logic                  rsp_saturated;

   tof_result_type pending_tof[$];
   int  errors = 0;
   int  words_sent = 0;
   int  words_checked = 0;
   int  sat_seen = 0;
   int  zden_seen = 0;
   int  neg_seen = 0;
   int  idle_count = 0;
   bit  sending_done = 1'b0;
   bit  quiet_sender = 1'b0;
   bit  quiet_receiver = 1'b0;

   ds_twr_time_of_flight dut (.*);

   // Free-running clock, 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Compute the expected flight time of one exchange.
   function automatic tof_result_type flight_time_of(exchange_type x);
      logic [STAMP_BITS-1:0] ra, rb, da, db;
      logic [DEN_W-1:0]      den;
      logic [MAG_W-1:0]      p1, p2, mag, quo;
      tof_result_type        r;
      ra  = x.resp_rx - x.poll_tx;
      db  = x.resp_tx - x.poll_rx;
      rb  = x.final_rx - x.resp_tx;
      da  = x.final_tx - x.resp_rx;
      den = DEN_W'(ra) + DEN_W'(rb) + DEN_W'(da) + DEN_W'(db);
      r   = '0;
      if (den == 0) begin
         r.zden = 1'b1;
         return r;
      end
      p1 = MAG_W'(ra) * MAG_W'(rb);
      p2 = MAG_W'(da) * MAG_W'(db);
      if (p1 >= p2) begin
         mag = p1 - p2;
         quo = mag / MAG_W'(den);
         if (quo > MAG_W'(32'h7FFF_FFFF)) begin
            r.tof = POS_LIMIT;
            r.sat = 1'b1;
         end else begin
            r.tof = quo[31:0];
         end
      end else begin
         mag = p2 - p1;
         quo = mag / MAG_W'(den);
         if (quo > MAG_W'(32'h8000_0000)) begin
            r.tof = NEG_LIMIT;
            r.sat = 1'b1;
         end else begin
            r.tof = -quo[31:0];
         end
      end
      return r;
   endfunction

   // Pick an idle length: mostly none or short, now and then long.
   function automatic int pick_gap(bit quiet);
      int roll;
      roll = $urandom_range(99);
      if (quiet || roll < 55) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   function automatic logic [STAMP_BITS-1:0] rand_stamp();
      return STAMP_BITS'({$urandom, $urandom});
   endfunction

   // Build one random exchange: mostly plausible timing, some pure noise.
   function automatic exchange_type random_exchange();
      exchange_type x;
      logic [STAMP_BITS-1:0] base, ofs;
      int spread;
      if ($urandom_range(99) < 25) begin
         x = {rand_stamp(), rand_stamp(), rand_stamp(),
              rand_stamp(), rand_stamp(), rand_stamp()};
         return x;
      end
      spread     = $urandom_range(3);
      base       = rand_stamp();
      ofs        = rand_stamp();
      x.poll_tx  = base;
      x.poll_rx  = ofs;
      x.resp_tx  = x.poll_rx + STAMP_BITS'($urandom_range(1 << (8 + 6 * spread)));
      x.resp_rx  = x.poll_tx + (x.resp_tx - x.poll_rx)
                   + STAMP_BITS'($urandom_range(1 << (6 + 6 * spread)));
      x.final_tx = x.resp_rx + STAMP_BITS'($urandom_range(1 << (8 + 6 * spread)));
      x.final_rx = x.resp_tx + (x.final_tx - x.resp_rx)
                   + STAMP_BITS'($urandom_range(1 << (6 + 6 * spread)));
      return x;
   endfunction

   // Offer one word and hold it until the block takes it.
   task automatic send_word(exchange_type x, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid               <= 1'b1;
      req_tag_poll_tx_time    <= x.poll_tx;
      req_anchor_resp_rx_time <= x.resp_rx;
      req_tag_final_tx_time   <= x.final_tx;
      req_anchor_resp_tx_time <= x.resp_tx;
      req_tag_final_rx_time   <= x.final_rx;
      req_tag_poll_rx_time    <= x.poll_rx;
      do @(posedge clock); while (req_stall);
      pending_tof.push_back(flight_time_of(x));
      words_sent++;
   endtask

   // Stimulus: directed table, then random words.
   initial begin
      directed_row_type rows[$];
      directed_row_type row;
      tof_result_type   got;
      exchange_type     x;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      rows.push_back('{'0, 1'b1, '{32'sd0, 1'b1, 1'b0}});
      rows.push_back('{{6{STAMP_MAX}}, 1'b1, '{32'sd0, 1'b1, 1'b0}});
      rows.push_back('{{STAMP_BITS'(0), STAMP_MAX, STAMP_MAX, STAMP_BITS'(0),
                        STAMP_MAX, STAMP_BITS'(0)}, 1'b1, '{POS_LIMIT, 1'b0, 1'b1}});
      rows.push_back('{{STAMP_BITS'(0), STAMP_BITS'(0), STAMP_MAX, STAMP_MAX,
                        STAMP_MAX, STAMP_BITS'(0)}, 1'b1, '{NEG_LIMIT, 1'b0, 1'b1}});
      // typical exchange, poll stamp wrapping past the top, reply-dominated
      rows.push_back('{{STAMP_BITS'(0), STAMP_BITS'(1000), STAMP_BITS'(2000),
                        STAMP_BITS'(5800), STAMP_BITS'(6800), STAMP_BITS'(5000)},
                       1'b0, '0});
      rows.push_back('{{STAMP_MAX, STAMP_BITS'(999), STAMP_BITS'(1999),
                        STAMP_BITS'(800), STAMP_BITS'(1800), STAMP_MAX},
                       1'b0, '0});
      rows.push_back('{{STAMP_BITS'(0), STAMP_BITS'(10), STAMP_BITS'(30),
                        STAMP_BITS'(20), STAMP_BITS'(30), STAMP_BITS'(0)},
                       1'b0, '0});
      rows.push_back('{{STAMP_BITS'(0), STAMP_BITS'(1), STAMP_BITS'(1),
                        STAMP_BITS'(0), STAMP_BITS'(0), STAMP_BITS'(0)},
                       1'b0, '0});
      rows.push_back('{{STAMP_BITS'(5), STAMP_BITS'(5), STAMP_BITS'(5),
                        STAMP_BITS'(5), STAMP_BITS'(5), STAMP_BITS'(4)},
                       1'b0, '0});
      rows.push_back('{{STAMP_BITS'(40'h55_5555_5555), STAMP_BITS'(40'hAA_AAAA_AAAA),
                        STAMP_BITS'(40'h55_5555_5555), STAMP_BITS'(40'hAA_AAAA_AAAA),
                        STAMP_BITS'(40'h55_5555_5555), STAMP_BITS'(40'hAA_AAAA_AAAA)},
                       1'b0, '0});

      // directed rows: compare the predictor against hand values where given
      foreach (rows[i]) begin
         row = rows[i];
         if (row.known) begin
            got = flight_time_of(row.stamps);
            if (got != row.answer) begin
               $error("directed row %0d: expected %h, predictor gave %h",
                      i, row.answer, got);
               errors++;
            end
         end
         send_word(row.stamps, pick_gap(1'b0));
      end

      // random words, with stretches of back-to-back traffic
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 100 == 0) quiet_sender = ($urandom_range(2) == 0);
         x = random_exchange();
         send_word(x, pick_gap(quiet_sender));
      end
      req_valid    <= 1'b0;
      sending_done  = 1'b1;
   end

   // Result side: check accepted words and drive the stall.
   initial begin
      tof_result_type want;
      int hold;
      bit pressed;
      hold    = 0;
      pressed = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            words_checked++;
            if (pending_tof.size() == 0) begin
               $error("result word with nothing expected: tof=%0d", rsp_flight_time);
               errors++;
            end else begin
               want = pending_tof.pop_front();
               if (rsp_flight_time !== want.tof) begin
                  $error("flight_time: expected %0d, got %0d", want.tof, rsp_flight_time);
                  errors++;
               end
               if (rsp_zero_denominator !== want.zden) begin
                  $error("zero_denominator: expected %0b, got %0b",
                         want.zden, rsp_zero_denominator);
                  errors++;
               end
               if (rsp_saturated !== want.sat) begin
                  $error("saturated: expected %0b, got %0b", want.sat, rsp_saturated);
                  errors++;
               end
               if (want.sat) sat_seen++;
               if (want.zden) zden_seen++;
               if (want.tof < 0) neg_seen++;
            end
         end
         // one long hold-off while the sender keeps offering words
         if (!pressed && words_sent >= 300) begin
            pressed = 1'b1;
            hold    = LONG_HOLD;
         end
         if (hold > 0) begin
            hold--;
            rsp_stall <= (hold != 0);
         end else begin
            if (words_checked % 150 == 0) quiet_receiver = ($urandom_range(2) == 0);
            hold = pick_gap(quiet_receiver);
            rsp_stall <= (hold != 0);
         end
      end
   end

   // Watchdog and end of run.
   initial begin
      int settle;
      settle = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
            idle_count = 0;
         else
            idle_count++;
         if (idle_count >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
         if (sending_done && pending_tof.size() == 0) begin
            settle++;
            if (settle >= DRAIN_CYCLES) begin
               $display("covered %0d words: %0d saturated, %0d zero denominator, %0d negative",
                        words_checked, sat_seen, zden_seen, neg_seen);
               if (errors == 0)
                  $display("ALL CHECKS PASSED");
               else
                  $display("CHECKS FAILED");
               $finish;
            end
         end
      end
   end

endmodule
